@@ hdl/brsb_pkg.sv @@
// ----------------------------------------------------------------------------
// brsb_pkg
// Shared constants, command codes and controller/datapath interface types
// for the binary range-sort bitmap.
// ----------------------------------------------------------------------------
package brsb_pkg;

  localparam int DEPTH      = 1024;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NWORDS     = DEPTH / WORD_W;
  localparam int WADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  localparam int THR_W      = 32;
  localparam int LEN_W      = 11;
  localparam int BW_W       = CNT_W - BIT_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEN = 1'b1;
  localparam logic [LEN_W-1:0]     LEN_RESET      = LEN_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 3'd0,
    CMD_SORT_UP   = 3'd1,
    CMD_SORT_DOWN = 3'd2,
    CMD_READ      = 3'd3,
    CMD_COUNT     = 3'd4
  } cmd_t;

  typedef struct packed {
    logic latch;
    logic dec_init;
    logic ptr_rst;
    logic ptr_inc;
    logic rd_en;
    logic cnt_acc;
    logic fil_wr;
    logic pt_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_point;
    logic is_sort;
    logic last_word;
  } dp_sts_t;

endpackage

@@ hdl/brsb_dp.sv @@
// ----------------------------------------------------------------------------
// brsb_dp
// Datapath: config registers, item latch, word-wide bit store with per-word
// valid bits, range masks, ones counter, sort fill and result register.
// ----------------------------------------------------------------------------
module brsb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [brsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [brsb_pkg::CMD_W-1:0]      in_cmd,
  input  logic [brsb_pkg::IDX_W-1:0]      in_index_lo,
  input  logic [brsb_pkg::IDX_W-1:0]      in_index_hi,
  input  logic [brsb_pkg::VAL_W-1:0]      in_value,
  input  brsb_pkg::dp_cmd_t               cmd,
  output brsb_pkg::dp_sts_t               sts,
  output logic [brsb_pkg::CNT_W-1:0]      out_count,
  output logic                            out_status
);
  import brsb_pkg::*;

  localparam logic [WORD_W-1:0] ONES = '1;

  logic [THR_W-1:0]   threshold_r;
  logic [LEN_W-1:0]   active_len_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [IDX_W-1:0]   lo_r, hi_r;
  logic [VAL_W-1:0]   value_r;
  logic [WADDR_W-1:0] ptr_r;
  logic [CNT_W-1:0]   acc_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_status_r;

  logic [WORD_W-1:0]  mem [NWORDS];
  logic [NWORDS-1:0]  wvalid_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_vld_r;

  logic [LEN_W-1:0]   len;
  logic               bad;
  logic [WADDR_W-1:0] lo_word, hi_word;
  logic [BIT_W-1:0]   lo_bit, hi_bit;
  logic [WORD_W-1:0]  old_w, rmask, pat, ge_m, wdata;
  logic [CNT_W-1:0]   bnd;
  logic [BW_W-1:0]    ptr_x;
  logic               we;

  assign lo_word = lo_r[IDX_W-1:BIT_W];
  assign hi_word = hi_r[IDX_W-1:BIT_W];
  assign lo_bit  = lo_r[BIT_W-1:0];
  assign hi_bit  = hi_r[BIT_W-1:0];
  assign len     = (active_len_r < LEN_W'(DEPTH)) ? active_len_r : LEN_W'(DEPTH);

  always_comb begin
    unique case (cmd_r) inside
      CMD_LOAD, CMD_READ: begin
        bad          = LEN_W'(lo_r) >= len;
        sts.is_point = 1'b1;
        sts.is_sort  = 1'b0;
      end
      CMD_SORT_UP, CMD_SORT_DOWN, CMD_COUNT: begin
        bad          = (lo_r > hi_r) || (LEN_W'(hi_r) >= len);
        sts.is_point = 1'b0;
        sts.is_sort  = (cmd_r != CMD_COUNT);
      end
      default: begin
        bad          = 1'b1;
        sts.is_point = 1'b0;
        sts.is_sort  = 1'b0;
      end
    endcase
    sts.bad       = bad;
    sts.last_word = (ptr_r == hi_word);
  end

  assign old_w = rd_vld_r ? rd_data_r : '0;
  assign rmask = ((ptr_r == lo_word) ? (ONES << lo_bit) : ONES) &
                 ((ptr_r == hi_word) ? (ONES >> (BIT_W'(WORD_W - 1) - hi_bit)) : ONES);

  assign bnd   = (cmd_r == CMD_SORT_UP) ? (CNT_W'(hi_r) + CNT_W'(1) - acc_r)
                                        : (CNT_W'(lo_r) + acc_r);
  assign ptr_x = BW_W'(ptr_r);
  assign ge_m  = (ptr_x > bnd[CNT_W-1:BIT_W]) ? ONES :
                 (ptr_x == bnd[CNT_W-1:BIT_W]) ? (ONES << bnd[BIT_W-1:0]) : '0;
  assign pat   = (cmd_r == CMD_SORT_UP) ? ge_m : ~ge_m;

  always_comb begin
    wdata = old_w;
    if (cmd.fil_wr) begin
      wdata = (old_w & ~rmask) | (pat & rmask);
    end else begin
      wdata[lo_bit] = (value_r > threshold_r);
    end
  end

  assign we = cmd.fil_wr || (cmd.pt_wr && (cmd_r == CMD_LOAD));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ptr_r] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r     <= '0;
      rd_vld_r     <= 1'b0;
      threshold_r  <= '0;
      active_len_r <= LEN_RESET;
    end else begin
      if (we) begin
        wvalid_r[ptr_r] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= wvalid_r[ptr_r];
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:  threshold_r  <= cfg_data;
          CFG_ACTIVE_LEN: active_len_r <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r   <= in_cmd;
      lo_r    <= in_index_lo;
      hi_r    <= in_index_hi;
      value_r <= in_value;
    end
    if (cmd.dec_init) begin
      ptr_r <= lo_word;
      acc_r <= '0;
    end else begin
      if (cmd.ptr_rst) begin
        ptr_r <= lo_word;
      end else if (cmd.ptr_inc) begin
        ptr_r <= ptr_r + WADDR_W'(1);
      end
      if (cmd.cnt_acc) begin
        acc_r <= acc_r + CNT_W'($countones(old_w & rmask));
      end else if (cmd.pt_wr && (cmd_r == CMD_READ)) begin
        acc_r <= CNT_W'(old_w[lo_bit]);
      end
    end
    if (cmd.out_load) begin
      out_count_r  <= bad ? '0 : acc_r;
      out_status_r <= bad;
    end
  end

  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

@@ hdl/brsb_ctl.sv @@
// ----------------------------------------------------------------------------
// brsb_ctl
// Controller: sequences decode, per-word count and fill passes, and owns
// the input stall and the result valid.
// ----------------------------------------------------------------------------
module brsb_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  brsb_pkg::dp_sts_t sts,
  output brsb_pkg::dp_cmd_t cmd
);
  import brsb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_PT_RD, S_PT_EV, S_CNT_RD, S_CNT_EV,
    S_FIL_RD, S_FIL_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !(out_valid_r && out_stall);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.dec_init = 1'b1;
        if (sts.bad)           state_nxt = S_DONE;
        else if (sts.is_point) state_nxt = S_PT_RD;
        else                   state_nxt = S_CNT_RD;
      end
      S_PT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PT_EV;
      end
      S_PT_EV: begin
        cmd.pt_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_CNT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CNT_EV;
      end
      S_CNT_EV: begin
        cmd.cnt_acc = 1'b1;
        if (!sts.last_word) begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_CNT_RD;
        end else if (sts.is_sort) begin
          cmd.ptr_rst = 1'b1;
          state_nxt   = S_FIL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIL_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_FIL_WR;
      end
      S_FIL_WR: begin
        cmd.fil_wr = 1'b1;
        if (sts.last_word) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_FIL_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/binary_range_sort_bitmap.sv @@
// ----------------------------------------------------------------------------
// binary_range_sort_bitmap
// Bitmap of 1024 positions with load, point read, range count and range
// sort (ascending or descending) commands; one result item per input item.
// ----------------------------------------------------------------------------
// The bitmap lives in a single-port memory of 64-bit words; every word is
// read and then processed in the following cycle. A load or point read
// decodes, then reads and processes its word; a range count reads and counts
// each word in the range (up to 16), and a range sort then rewrites those
// words in a second pass. A bad range or unknown command goes from decode
// to the result. The next item is accepted as soon as the result is handed
// to the output register, even while it still waits. Reset clears the valid
// bits at once, so there is no clearing pass; configuration is taken in any cycle.
// ----------------------------------------------------------------------------
module binary_range_sort_bitmap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [brsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brsb_pkg::CMD_W-1:0]      in_cmd,
  input  logic [brsb_pkg::IDX_W-1:0]      in_index_lo,
  input  logic [brsb_pkg::IDX_W-1:0]      in_index_hi,
  input  logic [brsb_pkg::VAL_W-1:0]      in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brsb_pkg::CNT_W-1:0]      out_count,
  output logic                            out_status
);
  import brsb_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  brsb_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  brsb_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_cmd      (in_cmd),
    .in_index_lo (in_index_lo),
    .in_index_hi (in_index_hi),
    .in_value    (in_value),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .out_count   (out_count),
    .out_status  (out_status)
  );

endmodule

@@ hdl/brsb_chk.sv @@
// ----------------------------------------------------------------------------
// brsb_chk
// Port-level checks for the binary range-sort bitmap, bound to the top.
// ----------------------------------------------------------------------------
module brsb_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [brsb_pkg::CNT_W-1:0] out_count,
  input logic                       out_status
);
  import brsb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_count == '0)
    else $error("bad request with nonzero count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= CNT_W'(DEPTH))
    else $error("count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted item without going busy");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_range_sort_bitmap brsb_chk u_chk (.*);
